FILE: rtl/jis_to_sjis_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the jis to sjis decoder
// ----------------------------------------------------------------------------
`ifndef JIS_TO_SJIS_DECODER_TOP_MACROS_SVH
`define JIS_TO_SJIS_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that holds whenever out of reset
`define JTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in the cycle after a trigger
`define JTS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define JTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define JTS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

FILE: rtl/jts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_pkg
// types and constants shared by the iso-2022-jp to shift_jis decoder
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_DOLLAR = 8'h24;
    localparam logic [7:0] BYTE_PAREN  = 8'h28;
    localparam logic [7:0] ROW_BASE    = 8'h70;
    localparam logic [7:0] COL_ODD     = 8'h1F;
    localparam logic [7:0] COL_EVEN    = 8'h7D;
    localparam logic [7:0] ROW_GAP_LO  = 8'hA0;
    localparam logic [7:0] ROW_GAP_ADD = 8'h40;
    localparam logic [7:0] COL_GAP_LO  = 8'h7F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } t_out_item;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_MODE,
        ESC_FINAL
    } t_esc_state;

    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_DOUBLE,
        CMD_MARKER
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: rtl/jts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_front
// accepts input bytes, tracks escape and pair state, issues output commands
// ----------------------------------------------------------------------------
module jts_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  jts_pkg::t_in_item      i_data,
    output logic                   o_stall,
    input  jts_pkg::t_queue_status i_status,
    output logic                   o_push,
    output jts_pkg::t_cmd          o_cmd
);
    import jts_pkg::*;

    t_esc_state r_esc, n_esc;
    logic       r_mode, n_mode;
    logic       r_pending, n_pending;
    logic [7:0] r_first, n_first;

    logic       w_accept;
    logic       w_esc_start;
    logic       w_emit_single;
    logic       w_emit_double;
    logic [7:0] w_half;
    logic [7:0] w_s1_raw;
    logic [7:0] w_s2_raw;
    logic [7:0] w_s1;
    logic [7:0] w_s2;

    assign o_stall     = i_status.full;
    assign w_accept    = i_valid && !i_status.full;
    assign w_esc_start = !r_pending && (i_data.in_byte == BYTE_ESC);

    // next state
    always_comb begin
        n_esc     = r_esc;
        n_mode    = r_mode;
        n_pending = r_pending;
        n_first   = r_first;
        if (w_accept) begin
            case (r_esc)
                ESC_MODE: begin
                    if (i_data.in_byte == BYTE_DOLLAR) begin
                        n_mode = 1'b1;
                    end else if (i_data.in_byte == BYTE_PAREN) begin
                        n_mode = 1'b0;
                    end
                    n_esc = ESC_FINAL;
                end
                ESC_FINAL: begin
                    n_esc = ESC_IDLE;
                end
                ESC_IDLE: begin
                    if (w_esc_start) begin
                        n_esc = ESC_MODE;
                    end else if (r_mode) begin
                        if (!r_pending) begin
                            n_pending = 1'b1;
                            n_first   = i_data.in_byte;
                        end else begin
                            n_pending = 1'b0;
                            n_first   = 8'h00;
                        end
                    end
                end
                default: begin
                    n_esc = ESC_IDLE;
                end
            endcase
            // end of string drops any half-finished pair or escape
            if (i_data.in_last) begin
                n_esc     = ESC_IDLE;
                n_mode    = 1'b0;
                n_pending = 1'b0;
                n_first   = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc     <= ESC_IDLE;
            r_mode    <= 1'b0;
            r_pending <= 1'b0;
            r_first   <= 8'h00;
        end else begin
            r_esc     <= n_esc;
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_first   <= n_first;
        end
    end

    // odd/even row rule, (j1 + 1) / 2 for odd j1 without a ninth bit
    assign w_half   = {1'b0, r_first[7:1]} + {7'd0, r_first[0]};
    assign w_s1_raw = w_half + ROW_BASE;
    assign w_s2_raw = i_data.in_byte + (r_first[0] ? COL_ODD : COL_EVEN);
    assign w_s1     = (w_s1_raw >= ROW_GAP_LO) ? (w_s1_raw + ROW_GAP_ADD) : w_s1_raw;
    assign w_s2     = (w_s2_raw >= COL_GAP_LO) ? (w_s2_raw + 8'd1) : w_s2_raw;

    // outputs
    always_comb begin
        w_emit_single = 1'b0;
        w_emit_double = 1'b0;
        case (r_esc)
            ESC_IDLE: begin
                w_emit_single = !w_esc_start && !r_mode;
                w_emit_double = !w_esc_start && r_mode && r_pending;
            end
            default: begin
                w_emit_single = 1'b0;
                w_emit_double = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_push      = w_accept && (w_emit_single || w_emit_double || i_data.in_last);
        o_cmd.last  = i_data.in_last;
        o_cmd.byte0 = i_data.in_byte;
        o_cmd.byte1 = w_s2;
        o_cmd.kind  = CMD_MARKER;
        if (w_emit_double) begin
            o_cmd.kind  = CMD_DOUBLE;
            o_cmd.byte0 = w_s1;
        end else if (w_emit_single) begin
            o_cmd.kind = CMD_SINGLE;
        end
    end

endmodule

FILE: rtl/jts_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_fifo
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module jts_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  jts_pkg::t_cmd          i_cmd,
    input  logic                   i_pop,
    output jts_pkg::t_cmd          o_cmd,
    output jts_pkg::t_queue_status o_status
);
    import jts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/jts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_back
// turns queued commands into one or two output beats
// ----------------------------------------------------------------------------
`include "jis_to_sjis_decoder_top_macros.svh"

module jts_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  jts_pkg::t_queue_status i_status,
    input  jts_pkg::t_cmd          i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    output jts_pkg::t_out_item     o_data,
    input  logic                   i_stall
);
    import jts_pkg::*;

    logic r_second, n_second;
    logic w_take;

    assign o_valid = !i_status.empty;
    assign w_take  = o_valid && !i_stall;
    assign o_pop   = w_take && ((i_cmd.kind != CMD_DOUBLE) || r_second);

    always_comb begin
        n_second = r_second;
        if (w_take && (i_cmd.kind == CMD_DOUBLE)) begin
            n_second = !r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

    always_comb begin
        case (i_cmd.kind)
            CMD_SINGLE: begin
                o_data = '{out_byte: i_cmd.byte0, out_valid: 1'b1, out_last: i_cmd.last};
            end
            CMD_DOUBLE: begin
                // lead byte never closes the string
                if (r_second) begin
                    o_data = '{out_byte: i_cmd.byte1, out_valid: 1'b1,
                               out_last: i_cmd.last};
                end else begin
                    o_data = '{out_byte: i_cmd.byte0, out_valid: 1'b1, out_last: 1'b0};
                end
            end
            default: begin
                o_data = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};
            end
        endcase
    end

    `JTS_ASSERT(a_second_on_double, i_clk, i_rst_n, !r_second || (o_valid && i_cmd.kind == CMD_DOUBLE), "trail beat pending without a double command at the head")
    `JTS_ASSERT_NEXT(a_trail_clears, i_clk, i_rst_n, w_take && r_second, !r_second, "trail beat phase did not clear after delivery")
    `JTS_ASSERT(a_lead_not_last, i_clk, i_rst_n, !(o_valid && i_cmd.kind == CMD_DOUBLE && !r_second) || !o_data.out_last, "lead byte of a pair marked last")

endmodule

FILE: rtl/jis_to_sjis_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jis_to_sjis_decoder_top
// iso-2022-jp byte stream to shift_jis byte stream decoder
// ----------------------------------------------------------------------------
// One input byte is accepted every cycle while the command queue has room;
// o_in_stall rises only when the QUEUE_DEPTH-entry queue is full. Commands are
// registered in the queue, and the back end turns the head into beats. A copied
// byte or an end-of-string marker takes one output beat, a converted double-byte
// pair takes two beats from the back end, so the output side delivers one beat
// per cycle while the queue is not empty and i_out_stall is low; the queue absorbs
// the burst of a pair. Escape sequences and the first byte of a pair produce no
// beat. A byte with in_last set closes the string: its last beat carries out_last,
// or a bare marker with out_valid low is sent, and the mode returns to single-byte.
module jis_to_sjis_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  jts_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output jts_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import jts_pkg::*;

    t_queue_status w_status;
    t_cmd          w_push_cmd;
    t_cmd          w_head_cmd;
    logic          w_push;
    logic          w_pop;

    jts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .o_stall  (o_in_stall),
        .i_status (w_status),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    jts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_status)
    );

    jts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .i_cmd    (w_head_cmd),
        .o_pop    (w_pop),
        .o_valid  (o_out_valid),
        .o_data   (o_out_data),
        .i_stall  (i_out_stall)
    );

endmodule
